// ===== hdl/amdf_pkg.sv =====
// Package for the average magnitude difference block.
// Holds the shared widths and the control struct between the top level and the lag cells.
// Depends on nothing.
`timescale 1ns / 1ps

package amdf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DIFF_W   = 16;
    localparam int ACC_W    = 22;
    localparam int LAG_W    = 6;
    localparam int LEN_W    = 7;

    typedef struct packed {
        logic load;
        logic drain;
        logic clear;
    } cell_ctrl_t;

endpackage

// ===== hdl/amdf_cell.sv =====
// One lag cell of the difference array: holds a delayed sample and its lag's running sum.
// Depends on amdf_pkg.
`timescale 1ns / 1ps

module amdf_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  amdf_pkg::cell_ctrl_t                ctrl,
    input  logic signed [amdf_pkg::SAMPLE_W-1:0] sample_in,
    input  logic signed [amdf_pkg::SAMPLE_W-1:0] tap_in,
    input  logic                                tap_valid_in,
    input  logic        [amdf_pkg::ACC_W-1:0]    acc_in,
    output logic signed [amdf_pkg::SAMPLE_W-1:0] tap_out,
    output logic                                tap_valid_out,
    output logic        [amdf_pkg::ACC_W-1:0]    acc_out
);
    import amdf_pkg::*;

    logic signed [SAMPLE_W-1:0] tap_reg;
    logic                       tv_reg;
    logic                       tv_next;
    logic        [ACC_W-1:0]    acc_reg;
    logic        [ACC_W-1:0]    acc_next;
    logic signed [SAMPLE_W:0]   diff;
    logic        [DIFF_W-1:0]   mag;

    always_comb
    begin
        diff = {sample_in[SAMPLE_W-1], sample_in} - {tap_in[SAMPLE_W-1], tap_in};
        if (diff[SAMPLE_W])
        begin
            mag = DIFF_W'(-diff);
        end
        else
        begin
            mag = DIFF_W'(diff);
        end
    end

    always_comb
    begin
        tv_next  = tv_reg;
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            tv_next  = 1'b0;
            acc_next = '0;
        end
        else if (ctrl.load)
        begin
            tv_next = tap_valid_in;
            if (tap_valid_in)
            begin
                acc_next = acc_reg + ACC_W'(mag);
            end
        end
        else if (ctrl.drain)
        begin
            acc_next = acc_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            tv_reg  <= tv_next;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            tap_reg <= tap_in;
        end
    end

    assign tap_out       = tap_reg;
    assign tap_valid_out = tv_reg;
    assign acc_out       = acc_reg;

endmodule

// ===== hdl/amdf_frame_lags_top.sv =====
// Top level of the average magnitude difference block: control and the row of lag cells.
// Depends on amdf_pkg and amdf_cell.
`timescale 1ns / 1ps

// A frame of frame_length samples enters at one word per cycle; each sample shifts down a
// row of MAX_FRAME lag cells, and every cell adds the magnitude of the new sample minus its
// delayed tap to the sum for its lag. When the frame is full, the sums leave in rising lag
// order at one word per cycle while out_stall is low, by shifting toward the first cell. Input is
// stalled during the drain. A frame_length of 0 acts as 1, and values above MAX_FRAME act
// as MAX_FRAME. Writing frame_length discards a partial frame.
module amdf_frame_lags_top #(
    parameter int MAX_FRAME = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [amdf_pkg::LEN_W-1:0]          frame_length,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [amdf_pkg::SAMPLE_W-1:0] sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [amdf_pkg::LAG_W-1:0]          lag,
    output logic [amdf_pkg::ACC_W-1:0]          amdf_value,
    output logic                                last
);
    import amdf_pkg::*;

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;
    logic [LEN_W-1:0]   fill_reg;
    logic [LEN_W-1:0]   fill_next;
    logic [LAG_W-1:0]   lag_reg;
    logic [LAG_W-1:0]   lag_next;
    logic [LEN_W-1:0]   eff_len;
    logic               in_take;
    logic               out_take;
    cell_ctrl_t         ctrl;

    logic signed [SAMPLE_W-1:0] tap   [MAX_FRAME];
    logic                       tv    [MAX_FRAME];
    logic        [ACC_W-1:0]    acc   [MAX_FRAME];

    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(MAX_FRAME))
        begin
            eff_len = LEN_W'(MAX_FRAME);
        end
        else
        begin
            eff_len = len_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_FILL);
    assign out_valid = (state_reg == ST_DRAIN);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid && !out_stall;
    assign lag       = lag_reg;
    assign amdf_value = acc[0];
    assign last      = ({1'b0, lag_reg} == (eff_len - LEN_W'(1)));

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        fill_next  = fill_reg;
        lag_next   = lag_reg;
        ctrl       = '0;
        if (cfg_valid && cfg_ready)
        begin
            len_next   = frame_length;
            fill_next  = '0;
            lag_next   = '0;
            state_next = ST_FILL;
            ctrl.clear = 1'b1;
        end
        else
        begin
            case (state_reg)
                ST_FILL:
                begin
                    if (in_take)
                    begin
                        ctrl.load = 1'b1;
                        if ((fill_reg + LEN_W'(1)) >= eff_len)
                        begin
                            fill_next  = '0;
                            lag_next   = '0;
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            fill_next = fill_reg + LEN_W'(1);
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (out_take)
                    begin
                        if (last)
                        begin
                            ctrl.clear = 1'b1;
                            lag_next   = '0;
                            state_next = ST_FILL;
                        end
                        else
                        begin
                            ctrl.drain = 1'b1;
                            lag_next   = lag_reg + LAG_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_next = ST_FILL;
                    ctrl.clear = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            len_reg   <= LEN_W'(64);
            fill_reg  <= '0;
            lag_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            fill_reg  <= fill_next;
            lag_reg   <= lag_next;
        end
    end

    for (genvar t = 0; t < MAX_FRAME; t++)
    begin : g_cell
        logic signed [SAMPLE_W-1:0] tap_src;
        logic                       tv_src;
        logic        [ACC_W-1:0]    acc_src;

        if (t == 0)
        begin : g_head
            assign tap_src = sample;
            assign tv_src  = 1'b1;
        end
        else
        begin : g_body
            assign tap_src = tap[t-1];
            assign tv_src  = tv[t-1];
        end

        if (t == MAX_FRAME - 1)
        begin : g_tail
            assign acc_src = '0;
        end
        else
        begin : g_link
            assign acc_src = acc[t+1];
        end

        amdf_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .sample_in     (sample),
            .tap_in        (tap_src),
            .tap_valid_in  (tv_src),
            .acc_in        (acc_src),
            .tap_out       (tap[t]),
            .tap_valid_out (tv[t]),
            .acc_out       (acc[t])
        );
    end

`ifndef SYNTHESIS
    // Results and samples never move in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("output word shown while input is open");

    // After the final lag is taken the block returns to filling.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last) |=> !out_valid)
        else $error("drain continued past the final lag");

    // The lag never runs past the frame length.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, lag} < eff_len))
        else $error("lag beyond frame length");

    // Lag zero compares each sample with itself.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && lag == '0) |-> (amdf_value == '0))
        else $error("nonzero sum at lag zero");
`endif

endmodule
